### hdl/lup_pkg.sv
// ----------------------------------------------------------------------------
// lup_pkg
// Shared constants, weight tables and types of the Lagrange upsampler.
// ----------------------------------------------------------------------------
package lup_pkg;

  localparam int UPSAMPLE    = 10;
  localparam int SAMPLE_BITS = 16;
  // interp_order is a 2-bit register, so cubic is the top order
  localparam int MAX_ORDER   = 3;
  localparam int ORD_BITS    = 2;
  localparam int KIDX_BITS   = 2;
  localparam int STORE_DEPTH = MAX_ORDER + 1;
  localparam int PH_BITS     = $clog2(UPSAMPLE);

  localparam logic [ORD_BITS-1:0] ORD_LINEAR = ORD_BITS'(1);
  localparam logic [PH_BITS-1:0]  PH_LAST    = PH_BITS'(UPSAMPLE - 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // order! * UPSAMPLE^order
  function automatic longint scale_c(int m);
    longint c;
    c = 1;
    for (int i = 1; i <= m; i++) begin
      c = c * longint'(i) * longint'(UPSAMPLE);
    end
    return c;
  endfunction

  localparam longint C1 = scale_c(1);
  localparam longint C2 = scale_c(2);
  localparam longint C3 = scale_c(3);

  // rounding divisor 2*C, reciprocal shift, reciprocal, saturation limit
  localparam longint D1 = 2 * C1;
  localparam longint D2 = 2 * C2;
  localparam longint D3 = 2 * C3;
  localparam int     S1 = SAMPLE_BITS - 1 + $clog2(D1);
  localparam int     S2 = SAMPLE_BITS - 1 + $clog2(D2);
  localparam int     S3 = SAMPLE_BITS - 1 + $clog2(D3);
  localparam longint R1 = (longint'(1) << S1) / D1;
  localparam longint R2 = (longint'(1) << S2) / D2;
  localparam longint R3 = (longint'(1) << S3) / D3;
  localparam longint L1 = (longint'(1) << (SAMPLE_BITS - 1)) * D1;
  localparam longint L2 = (longint'(1) << (SAMPLE_BITS - 1)) * D2;
  localparam longint L3 = (longint'(1) << (SAMPLE_BITS - 1)) * D3;

  localparam int WT_BITS   = $clog2(C3) + 2;
  localparam int PROD_BITS = SAMPLE_BITS + WT_BITS;
  localparam int ACC_BITS  = PROD_BITS + 2;
  localparam int N_BITS    = ACC_BITS + 1;
  localparam int NR_BITS   = S3;
  localparam int R_BITS    = SAMPLE_BITS;
  localparam int MUL_BITS  = NR_BITS + R_BITS;
  localparam int SH_BITS   = $clog2(MUL_BITS);
  localparam int D_BITS    = $clog2(D3 + 1);
  localparam int Q_BITS    = SAMPLE_BITS - 1;

  // per-order tables; entry 0 mirrors linear
  typedef logic [MAX_ORDER:0][N_BITS-1:0]  n_tab_t;
  typedef logic [MAX_ORDER:0][D_BITS-1:0]  d_tab_t;
  typedef logic [MAX_ORDER:0][R_BITS-1:0]  r_tab_t;
  typedef logic [MAX_ORDER:0][SH_BITS-1:0] s_tab_t;

  localparam n_tab_t C_TAB   = {N_BITS'(C3), N_BITS'(C2), N_BITS'(C1), N_BITS'(C1)};
  localparam n_tab_t LIM_TAB = {N_BITS'(L3), N_BITS'(L2), N_BITS'(L1), N_BITS'(L1)};
  localparam d_tab_t D_TAB   = {D_BITS'(D3), D_BITS'(D2), D_BITS'(D1), D_BITS'(D1)};
  localparam r_tab_t R_TAB   = {R_BITS'(R3), R_BITS'(R2), R_BITS'(R1), R_BITS'(R1)};
  localparam s_tab_t S_TAB   = {SH_BITS'(S3), SH_BITS'(S2), SH_BITS'(S1), SH_BITS'(S1)};

  // weight ROM: one table per knot lane, addressed by {order, interval, phase}
  localparam int WT_AW    = ORD_BITS + KIDX_BITS + PH_BITS;
  localparam int WT_DEPTH = 1 << WT_AW;
  typedef logic [MAX_ORDER:0][WT_DEPTH-1:0][WT_BITS-1:0] wt_rom_t;

  // W_k(t) = prod_{i!=k}(t - i*U) * (-1)^(m-k) * binom(m,k)
  function automatic wt_rom_t build_wt_rom();
    wt_rom_t rom;
    longint  pas [0:MAX_ORDER];
    longint  nk;
    longint  t;
    int      addr;
    rom = '0;
    pas[0] = 1;
    for (int i = 1; i <= MAX_ORDER; i++) pas[i] = 0;
    for (int m = 1; m <= MAX_ORDER; m++) begin
      for (int i = m; i >= 1; i--) pas[i] = pas[i] + pas[i-1];
      for (int j = 0; j < m; j++) begin
        for (int ph = 0; ph < UPSAMPLE; ph++) begin
          t    = longint'(j * UPSAMPLE + ph);
          addr = (m << (KIDX_BITS + PH_BITS)) | (j << PH_BITS) | ph;
          for (int k = 0; k <= m; k++) begin
            nk = 1;
            for (int i = 0; i <= m; i++) begin
              if (i != k) nk = nk * (t - longint'(i * UPSAMPLE));
            end
            if (((m - k) & 1) != 0) nk = -nk;
            rom[k][addr] = WT_BITS'(nk * pas[k]);
          end
        end
      end
    end
    return rom;
  endfunction

  localparam wt_rom_t WT_ROM = build_wt_rom();

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEG,
    ST_TAIL,
    ST_PART
  } lup_state_t;

  // controller -> datapath
  typedef struct packed {
    logic                  issue;
    logic                  is_knot;
    logic [KIDX_BITS-1:0]  knot_idx;
    logic [ORD_BITS-1:0]   ord;
    logic [KIDX_BITS-1:0]  seg;
    logic [PH_BITS-1:0]    phase;
    logic                  part;
    logic                  last;
    logic                  wr_en;
    logic [KIDX_BITS-1:0]  wr_idx;
    sample_t               wr_data;
    logic                  shift_en;
    logic [KIDX_BITS-1:0]  shift_idx;
  } lup_cmd_t;

endpackage

### hdl/lup_datapath.sv
// ----------------------------------------------------------------------------
// lup_datapath
// Knot store, 4-lane weight multiply, rounding divide by reciprocal,
// saturation and output register.
// ----------------------------------------------------------------------------
module lup_datapath (
  input  logic              clk,
  input  logic              rst,
  input  lup_pkg::lup_cmd_t cmd,
  input  logic              out_ready,
  output logic              issue_ok,
  output logic              out_valid,
  output lup_pkg::sample_t  out_sample,
  output logic              is_knot,
  output logic              partial_segment,
  output logic              run_end
);
  import lup_pkg::*;

  localparam int NSTG = 7;
  localparam sample_t SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    logic [ORD_BITS-1:0] ord;
    logic                knot;
    logic                part;
    logic                last;
  } tag_t;

  logic adv;

  sample_t knot_store [STORE_DEPTH];

  logic                       vld [1:NSTG];
  tag_t                       tag [1:NSTG];
  logic signed [WT_BITS-1:0]  wsel [STORE_DEPTH];
  logic [WT_AW-1:0]           wt_addr;
  logic signed [PROD_BITS-1:0] p1 [STORE_DEPTH];
  logic signed [PROD_BITS:0]  s2a, s2b;
  logic signed [ACC_BITS-1:0] acc3;
  logic [N_BITS-1:0]          two_acc;
  logic                       neg4, neg5, neg6, neg7;
  logic [N_BITS-1:0]          n4;
  logic                       sat5, sat6, sat7;
  logic [NR_BITS-1:0]         n5, n6;
  logic [MUL_BITS-1:0]        prod5;
  logic [MUL_BITS-1:0]        sh6;
  logic [Q_BITS-1:0]          q0, q06;
  logic [NR_BITS-1:0]         qd6;
  logic [NR_BITS-1:0]         r7;
  logic [Q_BITS:0]            q7;

  assign adv      = !out_valid || out_ready;
  assign issue_ok = adv;

  // knot store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STORE_DEPTH; i++) knot_store[i] <= '0;
    end else begin
      if (cmd.wr_en) knot_store[cmd.wr_idx] <= cmd.wr_data;
      if (cmd.shift_en) knot_store[0] <= knot_store[cmd.shift_idx];
    end
  end

  // lane weights; a knot is a unit weight at linear scale
  assign wt_addr = {cmd.ord, cmd.seg, cmd.phase};
  always_comb begin
    for (int k = 0; k < STORE_DEPTH; k++) begin
      if (cmd.is_knot) begin
        wsel[k] = (cmd.knot_idx == KIDX_BITS'(k)) ? WT_BITS'(C1) : '0;
      end else begin
        wsel[k] = WT_ROM[k][wt_addr];
      end
    end
  end

  assign two_acc = {acc3, 1'b0};
  assign sh6     = prod5 >> S_TAB[tag[5].ord];
  assign q0      = sh6[Q_BITS-1:0];
  assign r7      = n6 - qd6;

  // valid and tag chain
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= NSTG; s++) vld[s] <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld[1] <= cmd.issue;
      for (int s = 2; s <= NSTG; s++) vld[s] <= vld[s-1];
      out_valid <= vld[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag[1].ord  <= cmd.is_knot ? ORD_LINEAR : cmd.ord;
      tag[1].knot <= cmd.is_knot;
      tag[1].part <= cmd.part;
      tag[1].last <= cmd.last;
      for (int s = 2; s <= NSTG; s++) tag[s] <= tag[s-1];

      // S1: lane products
      for (int k = 0; k < STORE_DEPTH; k++) begin
        p1[k] <= PROD_BITS'(knot_store[k]) * PROD_BITS'(wsel[k]);
      end
      // S2/S3: sum tree
      s2a  <= (PROD_BITS+1)'(p1[0]) + (PROD_BITS+1)'(p1[1]);
      s2b  <= (PROD_BITS+1)'(p1[2]) + (PROD_BITS+1)'(p1[3]);
      acc3 <= ACC_BITS'(s2a) + ACC_BITS'(s2b);
      // S4: 2|acc| + C
      neg4 <= acc3[ACC_BITS-1];
      n4   <= acc3[ACC_BITS-1] ? (C_TAB[tag[3].ord] - two_acc)
                               : (C_TAB[tag[3].ord] + two_acc);
      // S5: saturation check, reciprocal multiply
      neg5  <= neg4;
      sat5  <= n4 >= LIM_TAB[tag[4].ord];
      n5    <= n4[NR_BITS-1:0];
      prod5 <= MUL_BITS'(n4[NR_BITS-1:0]) * MUL_BITS'(R_TAB[tag[4].ord]);
      // S6: estimate and back-multiply
      neg6 <= neg5;
      sat6 <= sat5;
      n6   <= n5;
      q06  <= q0;
      qd6  <= NR_BITS'(q0) * NR_BITS'(D_TAB[tag[5].ord]);
      // S7: one-step correction
      neg7 <= neg6;
      sat7 <= sat6;
      q7   <= (Q_BITS+1)'(q06) + (Q_BITS+1)'(r7 >= NR_BITS'(D_TAB[tag[6].ord]));
      // output register
      if (sat7) begin
        out_sample <= neg7 ? SMIN : SMAX;
      end else begin
        out_sample <= neg7 ? -$signed(q7) : $signed(q7);
      end
      is_knot         <= tag[NSTG].knot;
      partial_segment <= tag[NSTG].part;
      run_end         <= tag[NSTG].last;
    end
  end

endmodule

### hdl/lup_ctrl.sv
// ----------------------------------------------------------------------------
// lup_ctrl
// Segment sequencer: takes knots, tracks segment fill, steps output points.
// ----------------------------------------------------------------------------
module lup_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lup_pkg::ORD_BITS-1:0] interp_order,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  lup_pkg::sample_t             knot_sample,
  input  logic                         final_knot,
  input  logic                         issue_ok,
  output lup_pkg::lup_cmd_t            cmd
);
  import lup_pkg::*;

  lup_state_t           state, state_next;
  logic [ORD_BITS-1:0]  order_reg;
  logic [KIDX_BITS-1:0] kis, kis_next;
  logic                 have_first, have_first_next;
  logic [KIDX_BITS-1:0] seg_m, seg_m_next;
  logic                 fin_q, fin_q_next;
  logic [KIDX_BITS-1:0] cnt_j, cnt_j_next;
  logic [PH_BITS-1:0]   cnt_ph, cnt_ph_next;

  logic [ORD_BITS-1:0]  eff_ord;
  logic [KIDX_BITS-1:0] m_new;
  logic                 seg_end;

  assign cfg_ready = 1'b1;
  assign eff_ord   = (order_reg == '0) ? ORD_LINEAR : order_reg;
  assign m_new     = kis + KIDX_BITS'(1);
  assign seg_end   = (cnt_j == seg_m - KIDX_BITS'(1)) && (cnt_ph == PH_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      order_reg  <= ORD_LINEAR;
      kis        <= '0;
      have_first <= 1'b0;
      seg_m      <= '0;
      fin_q      <= 1'b0;
      cnt_j      <= '0;
      cnt_ph     <= '0;
    end else begin
      state      <= state_next;
      kis        <= kis_next;
      have_first <= have_first_next;
      seg_m      <= seg_m_next;
      fin_q      <= fin_q_next;
      cnt_j      <= cnt_j_next;
      cnt_ph     <= cnt_ph_next;
      if (cfg_valid && cfg_ready) order_reg <= interp_order;
    end
  end

  always_comb begin
    state_next      = state;
    kis_next        = kis;
    have_first_next = have_first;
    seg_m_next      = seg_m;
    fin_q_next      = fin_q;
    cnt_j_next      = cnt_j;
    cnt_ph_next     = cnt_ph;
    in_ready        = 1'b0;

    cmd           = '0;
    cmd.ord       = seg_m;
    cmd.seg       = cnt_j;
    cmd.phase     = cnt_ph;
    cmd.knot_idx  = cnt_j;
    cmd.wr_idx    = m_new;
    cmd.wr_data   = knot_sample;
    cmd.shift_idx = seg_m;

    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.wr_en = 1'b1;
          if (!have_first) begin
            cmd.wr_idx = '0;
            kis_next   = '0;
            cnt_j_next = '0;
            if (final_knot) begin
              state_next      = ST_TAIL;
              have_first_next = 1'b0;
            end else begin
              have_first_next = 1'b1;
            end
          end else if (m_new >= eff_ord) begin
            state_next      = ST_SEG;
            seg_m_next      = m_new;
            cnt_j_next      = '0;
            cnt_ph_next     = '0;
            fin_q_next      = final_knot;
            kis_next        = '0;
            have_first_next = !final_knot;
          end else if (final_knot) begin
            state_next      = ST_PART;
            seg_m_next      = m_new;
            cnt_j_next      = '0;
            kis_next        = '0;
            have_first_next = 1'b0;
          end else begin
            kis_next = m_new;
          end
        end
      end

      ST_SEG: begin
        cmd.issue   = 1'b1;
        cmd.is_knot = (cnt_ph == '0);
        cmd.last    = seg_end && !fin_q;
        if (issue_ok) begin
          if (seg_end) begin
            // end knot becomes the next segment's start
            cmd.shift_en = 1'b1;
            if (fin_q) begin
              state_next = ST_TAIL;
              cnt_j_next = seg_m;
            end else begin
              state_next = ST_IDLE;
            end
          end else if (cnt_ph == PH_LAST) begin
            cnt_ph_next = '0;
            cnt_j_next  = cnt_j + KIDX_BITS'(1);
          end else begin
            cnt_ph_next = cnt_ph + PH_BITS'(1);
          end
        end
      end

      ST_TAIL: begin
        cmd.issue   = 1'b1;
        cmd.is_knot = 1'b1;
        cmd.last    = 1'b1;
        if (issue_ok) state_next = ST_IDLE;
      end

      ST_PART: begin
        cmd.issue   = 1'b1;
        cmd.is_knot = 1'b1;
        cmd.part    = 1'b1;
        cmd.last    = (cnt_j == seg_m);
        if (issue_ok) begin
          if (cnt_j == seg_m) begin
            state_next = ST_IDLE;
          end else begin
            cnt_j_next = cnt_j + KIDX_BITS'(1);
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/lagrange_upsample_by_ten.sv
// ----------------------------------------------------------------------------
// Result path: a result of a knot goes from the sequencer issue through the
//   7 datapath stages (S1-S7) to the output register; all of it stalls while held.
// Throughput: one result per cycle while the sequencer issues and the output
//   is not held; a segment of order m takes m accepted knots plus 10*m
//   issued points (one more on a final knot); no knot is taken while issuing.
// Reset (rst, synchronous): order back to linear, knot store zeroed,
//   pipeline emptied, waiting for a first knot. No clearing pass.
// ----------------------------------------------------------------------------
// lagrange_upsample_by_ten
// Rebuilds a x10 upsampled signal from knot samples with linear, quadratic
// or cubic Lagrange interpolation over segments that share their end knot.
// ----------------------------------------------------------------------------
module lagrange_upsample_by_ten (
  input  logic                         clk,
  input  logic                         rst,
  // order register write
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lup_pkg::ORD_BITS-1:0] interp_order,
  // knot requests
  input  logic                         in_valid,
  output logic                         in_ready,
  input  lup_pkg::sample_t             knot_sample,
  input  logic                         final_knot,
  // sample results
  output logic                         out_valid,
  input  logic                         out_ready,
  output lup_pkg::sample_t             out_sample,
  output logic                         is_knot,
  output logic                         partial_segment,
  output logic                         run_end
);
  import lup_pkg::*;

  lup_cmd_t cmd;
  logic     issue_ok;

  // Sequencer: owns the order register, segment fill and the point counters.
  // It takes a knot only when idle, then walks interval/phase and issues one
  // point request per cycle when the datapath can advance.
  lup_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .interp_order (interp_order),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .knot_sample  (knot_sample),
    .final_knot   (final_knot),
    .issue_ok     (issue_ok),
    .cmd          (cmd)
  );

  // Datapath: knot store read at issue, constant-weight products, sum tree,
  // round-to-nearest divide via reciprocal with one correction step,
  // saturation. The whole pipe stalls while the output register is held.
  // Knots pass through the same path as a unit linear weight.
  lup_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .out_ready       (out_ready),
    .issue_ok        (issue_ok),
    .out_valid       (out_valid),
    .out_sample      (out_sample),
    .is_knot         (is_knot),
    .partial_segment (partial_segment),
    .run_end         (run_end)
  );

  // a final knot always produces output, so the sequencer must go busy
  a_final_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && final_knot |=> !in_ready)
    else $error("final knot accepted but sequencer stayed idle");

  // partial-segment results are always knots passed through
  a_part_knot: assert property (@(posedge clk) disable iff (rst)
    out_valid && partial_segment |-> is_knot)
    else $error("partial segment result not flagged as knot");

  // the sequencer only leaves idle after taking a knot
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid))
    else $error("sequencer went busy without a knot request");

endmodule
